>>> design/svc_pkg.sv
// shared widths, codes and constants for the stepper scan velocity control
`timescale 1ns / 1ps

package svc_pkg;

    localparam int VEL_W      = 23;
    localparam int SPEED_W    = 22;
    localparam int PERIOD_W   = 31;
    localparam int COMPARE_W  = 30;
    localparam int REV_W      = 16;
    localparam int OP_W       = 2;
    localparam int LIMIT_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SPEED_W;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};
    localparam logic [SPEED_W-1:0]  MAX_SPEED_RESET = SPEED_W'(32768);

    // operation codes
    localparam logic [OP_W-1:0] OP_VELOCITY  = 2'd0;
    localparam logic [OP_W-1:0] OP_LIMIT_CW  = 2'd1;
    localparam logic [OP_W-1:0] OP_LIMIT_CCW = 2'd2;

    // latched limit codes
    localparam logic [LIMIT_W-1:0] LIM_NONE = 2'd0;
    localparam logic [LIMIT_W-1:0] LIM_CW   = 2'd1;
    localparam logic [LIMIT_W-1:0] LIM_CCW  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_MODE = 1'd1;

endpackage

>>> design/svc_cmd_if.sv
// command channel: velocity command or limit event
`timescale 1ns / 1ps

interface svc_cmd_if;
    import svc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic signed [VEL_W-1:0] velocity_cmd;

    modport source (output valid, output op, output velocity_cmd, input ready);
    modport sink (input valid, input op, input velocity_cmd, output ready);
endinterface

>>> design/svc_res_if.sv
// result channel: step timer setup and scan status
`timescale 1ns / 1ps

interface svc_res_if;
    import svc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    dir_cw;
    logic                    running;
    logic [PERIOD_W-1:0]     step_period;
    logic [COMPARE_W-1:0]    step_compare;
    logic signed [VEL_W-1:0] setpoint_out;
    logic [LIMIT_W-1:0]      latched_limit;
    logic [REV_W-1:0]        reversals;
    logic                    scan_ready;
    logic                    indicator;
    logic                    counter_restart;

    modport source (
        output valid, output dir_cw, output running, output step_period,
        output step_compare, output setpoint_out, output latched_limit,
        output reversals, output scan_ready, output indicator,
        output counter_restart, input ready
    );
    modport sink (
        input valid, input dir_cw, input running, input step_period,
        input step_compare, input setpoint_out, input latched_limit,
        input reversals, input scan_ready, input indicator,
        input counter_restart, output ready
    );
endinterface

>>> design/stepper_scan_velocity_control_top.sv
// stepper scan velocity control: command handling and step period divider
// path: an item that leaves the timer running goes through apply, the restoring divider steps,
//   period and done from accept to result valid, a stop or dead-zone item through apply
//   and done, an ignored limit event or unused op straight to done
// throughput: one item at a time; the next item is taken in the cycle after the result
//   is loaded, even while that result still waits on the result channel
// reset: asynchronous active low, state returns to stopped, clockwise, maximum period
`timescale 1ns / 1ps

module stepper_scan_velocity_control_top #(
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [svc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [svc_pkg::CFG_DATA_W-1:0]   cfg_data,
    svc_cmd_if.sink                          cmd,
    svc_res_if.source                        res
);
    import svc_pkg::*;

    // numerator 50 << FRAC_BITS needs FRAC_BITS + 6 bits
    localparam int NUM_W  = FRAC_BITS + 6;
    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam int WV_W   = VEL_W + 1;
    localparam logic [NUM_W-1:0] PERIOD_NUM = NUM_W'(50) << FRAC_BITS;
    // |v| * 1000 < 2^FRAC_BITS is the same as |v| below this bound
    localparam logic [VEL_W-1:0] DZ_LIM = VEL_W'(((1 << FRAC_BITS) + 999) / 1000);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_DIV,
        ST_PERIOD,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic [SPEED_W-1:0]      max_speed_reg;
    logic                    scan_mode_reg;
    logic signed [WV_W-1:0]  v_reg;
    logic signed [VEL_W-1:0] setpoint_reg;
    logic [LIMIT_W-1:0]      latch_reg;
    logic [COUNT_BITS-1:0]   count_reg;
    logic                    dir_reg;
    logic                    run_reg;
    logic [PERIOD_W-1:0]     period_reg;
    logic                    led_reg;
    logic                    restart_reg;

    logic [VEL_W-1:0]        div_reg;
    logic [VEL_W-1:0]        rem_reg;
    logic [NUM_W-1:0]        quot_reg;
    logic [STEP_W-1:0]       step_reg;

    logic                    res_valid_reg;
    logic                    res_dir_reg;
    logic                    res_run_reg;
    logic [PERIOD_W-1:0]     res_period_reg;
    logic signed [VEL_W-1:0] res_setpoint_reg;
    logic [LIMIT_W-1:0]      res_latch_reg;
    logic [REV_W-1:0]        res_rev_reg;
    logic                    res_scan_ready_reg;
    logic                    res_led_reg;
    logic                    res_restart_reg;

    logic [VEL_W-1:0]        sp_mag;
    logic                    sp_moving;
    logic                    toward_cw;
    logic                    toward_ccw;
    logic signed [WV_W-1:0]  lim;
    logic signed [WV_W-1:0]  v_clamp;
    logic signed [WV_W-1:0]  v_fin;
    logic [VEL_W-1:0]        v_mag;
    logic                    v_dead;
    logic [VEL_W:0]          trial;
    logic                    q_bit;
    logic [VEL_W-1:0]        rem_next;
    logic [32:0]             count_ext;
    logic                    slot_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg <= MAX_SPEED_RESET;
            scan_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_SPEED: max_speed_reg <= cfg_data;
                CFG_SCAN_MODE: scan_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // is the current setpoint moving toward a limit
    always_comb
    begin
        sp_mag     = setpoint_reg[VEL_W-1] ? VEL_W'(-setpoint_reg) : VEL_W'(setpoint_reg);
        sp_moving  = sp_mag >= DZ_LIM;
        toward_cw  = !setpoint_reg[VEL_W-1] && sp_moving;
        toward_ccw = setpoint_reg[VEL_W-1] && sp_moving;
    end

    // clamp, limit lockout and dead zone for the pending command
    always_comb
    begin
        lim = $signed({2'b00, max_speed_reg});
        if (v_reg > lim)
            v_clamp = lim;
        else if (v_reg < -lim)
            v_clamp = -lim;
        else
            v_clamp = v_reg;
        if ((v_clamp > 0 && latch_reg == LIM_CW) || (v_clamp < 0 && latch_reg == LIM_CCW))
            v_fin = '0;
        else
            v_fin = v_clamp;
        v_mag  = v_fin[WV_W-1] ? VEL_W'(-v_fin) : VEL_W'(v_fin);
        v_dead = v_mag < DZ_LIM;
    end

    // one restoring divider step
    always_comb
    begin
        trial    = {rem_reg, quot_reg[NUM_W-1]};
        q_bit    = trial >= {1'b0, div_reg};
        rem_next = q_bit ? VEL_W'(trial - {1'b0, div_reg}) : trial[VEL_W-1:0];
    end

    assign count_ext = 33'(count_reg);
    assign slot_free = !res_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            v_reg              <= '0;
            setpoint_reg       <= '0;
            latch_reg          <= LIM_NONE;
            count_reg          <= '0;
            dir_reg            <= 1'b1;
            run_reg            <= 1'b0;
            period_reg         <= PERIOD_MAX;
            led_reg            <= 1'b0;
            restart_reg        <= 1'b0;
            div_reg            <= '0;
            rem_reg            <= '0;
            quot_reg           <= '0;
            step_reg           <= '0;
            res_valid_reg      <= 1'b0;
            res_dir_reg        <= 1'b1;
            res_run_reg        <= 1'b0;
            res_period_reg     <= PERIOD_MAX;
            res_setpoint_reg   <= '0;
            res_latch_reg      <= LIM_NONE;
            res_rev_reg        <= '0;
            res_scan_ready_reg <= 1'b0;
            res_led_reg        <= 1'b0;
            res_restart_reg    <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_DONE && slot_free)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        restart_reg <= 1'b0;
                        unique case (cmd.op) inside
                            OP_VELOCITY:
                            begin
                                v_reg     <= {cmd.velocity_cmd[VEL_W-1], cmd.velocity_cmd};
                                state_reg <= ST_APPLY;
                            end
                            OP_LIMIT_CW, OP_LIMIT_CCW:
                            begin
                                if ((cmd.op == OP_LIMIT_CW && toward_cw)
                                    || (cmd.op == OP_LIMIT_CCW && toward_ccw))
                                begin
                                    state_reg <= ST_APPLY;
                                    if (scan_mode_reg)
                                    begin
                                        // reverse: negated setpoint goes through the command path
                                        if (count_reg != {COUNT_BITS{1'b1}})
                                            count_reg <= count_reg + 1'b1;
                                        led_reg <= (cmd.op == OP_LIMIT_CW);
                                        v_reg   <= -{setpoint_reg[VEL_W-1], setpoint_reg};
                                    end
                                    else
                                    begin
                                        latch_reg <= (cmd.op == OP_LIMIT_CW) ? LIM_CW : LIM_CCW;
                                        v_reg     <= '0;
                                    end
                                end
                                else
                                    state_reg <= ST_DONE;
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_APPLY:
                begin
                    setpoint_reg <= VEL_W'(v_fin);
                    if (v_dead)
                    begin
                        period_reg <= PERIOD_MAX;
                        run_reg    <= 1'b0;
                        state_reg  <= ST_DONE;
                    end
                    else
                    begin
                        dir_reg     <= !v_fin[WV_W-1];
                        latch_reg   <= LIM_NONE;
                        run_reg     <= 1'b1;
                        restart_reg <= 1'b1;
                        div_reg     <= v_mag;
                        rem_reg     <= '0;
                        quot_reg    <= PERIOD_NUM;
                        step_reg    <= '0;
                        state_reg   <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_reg  <= rem_next;
                    quot_reg <= {quot_reg[NUM_W-2:0], q_bit};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(NUM_W - 1))
                        state_reg <= ST_PERIOD;
                end
                ST_PERIOD:
                begin
                    // quotient is below 50 << FRAC_BITS, always under the maximum period
                    period_reg <= PERIOD_W'(quot_reg);
                    state_reg  <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (slot_free)
                    begin
                        res_dir_reg        <= dir_reg;
                        res_run_reg        <= run_reg;
                        res_period_reg     <= period_reg;
                        res_setpoint_reg   <= setpoint_reg;
                        res_latch_reg      <= latch_reg;
                        res_rev_reg        <= (count_ext > 33'd65535) ? {REV_W{1'b1}}
                                                                      : REV_W'(count_ext);
                        res_scan_ready_reg <= count_ext >= 33'd2;
                        res_led_reg        <= led_reg;
                        res_restart_reg    <= restart_reg;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign cmd.ready           = (state_reg == ST_IDLE);
    assign res.valid           = res_valid_reg;
    assign res.dir_cw          = res_dir_reg;
    assign res.running         = res_run_reg;
    assign res.step_period     = res_period_reg;
    assign res.step_compare    = res_period_reg[PERIOD_W-1:1];
    assign res.setpoint_out    = res_setpoint_reg;
    assign res.latched_limit   = res_latch_reg;
    assign res.reversals       = res_rev_reg;
    assign res.scan_ready      = res_scan_ready_reg;
    assign res.indicator       = res_led_reg;
    assign res.counter_restart = res_restart_reg;

    // a stopped timer always carries the maximum period, a running one never does
    a_run_period: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.running == (res.step_period != PERIOD_MAX)))
        else $error("running flag and step period disagree");

    // a counter restart means the motor runs and no limit stays latched
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.counter_restart |-> res.running && res.latched_limit == LIM_NONE)
        else $error("counter restart with stopped timer or latched limit");

    // reversal count only grows
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= $past(count_reg))
        else $error("reversal count went down");

endmodule

>>> dv/tb_top.sv
// self-checking testbench for the stepper scan velocity control block
`timescale 1ns / 1ps

module tb_top;
    import svc_pkg::*;

    localparam int FRAC_BITS      = 16;
    localparam int COUNT_BITS     = 16;
    localparam longint COUNT_MAX  = (longint'(1) << COUNT_BITS) - 1;
    localparam longint PERIOD_NUM = longint'(50) << FRAC_BITS;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_PCT       = 21;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_PHASES  = 6;
    localparam int CYCLE_LIMIT    = 600000;

    typedef struct packed {
        logic                    dir_cw;
        logic                    running;
        logic [PERIOD_W-1:0]     step_period;
        logic [COMPARE_W-1:0]    step_compare;
        logic signed [VEL_W-1:0] setpoint_out;
        logic [LIMIT_W-1:0]      latched_limit;
        logic [REV_W-1:0]        reversals;
        logic                    scan_ready;
        logic                    indicator;
        logic                    counter_restart;
    } step_setup_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    svc_cmd_if cmd_bus();
    svc_res_if res_bus();

    stepper_scan_velocity_control_top #(
        .FRAC_BITS(FRAC_BITS),
        .COUNT_BITS(COUNT_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .cmd(cmd_bus),
        .res(res_bus)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // shadow of the control state, kept in step with accepted items
    logic [SPEED_W-1:0]  speed_lim = MAX_SPEED_RESET;
    bit                  scan_on = 1'b1;
    longint              sp_now = 0;
    logic [LIMIT_W-1:0]  latch_now = LIM_NONE;
    longint              rev_now = 0;
    bit                  dir_now = 1'b1;
    bit                  run_now = 1'b0;
    logic [PERIOD_W-1:0] period_now = PERIOD_MAX;
    bit                  led_now = 1'b0;

    step_setup_t expected_setups[$];
    int  mismatches = 0;
    int  items_sent = 0;
    int  results_checked = 0;
    int  restarts_seen = 0;
    int  settings_loaded = 0;
    int  cycle_count = 0;
    bit  no_idle = 1'b0;
    bit  hold_off_req = 1'b0;

    function automatic longint vel_mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit in_dead_band(longint v);
        return vel_mag(v) * 1000 < (longint'(1) << FRAC_BITS);
    endfunction

    function automatic bit set_velocity(longint v);
        longint lim;
        longint p;
        lim = longint'(speed_lim);
        if (v > lim)
            v = lim;
        else if (v < -lim)
            v = -lim;
        // no motion into a latched limit
        if ((v > 0 && latch_now == LIM_CW) || (v < 0 && latch_now == LIM_CCW))
            v = 0;
        sp_now = v;
        if (in_dead_band(v))
        begin
            period_now = PERIOD_MAX;
            run_now = 1'b0;
            return 1'b0;
        end
        dir_now = (v > 0);
        latch_now = LIM_NONE;
        p = PERIOD_NUM / vel_mag(v);
        if (p > longint'(PERIOD_MAX))
            p = longint'(PERIOD_MAX);
        period_now = p[PERIOD_W-1:0];
        run_now = 1'b1;
        return 1'b1;
    endfunction

    function automatic bit hit_limit(bit cw);
        bit toward;
        bit restart;
        toward = cw ? (sp_now > 0 && !in_dead_band(sp_now))
                    : (sp_now < 0 && !in_dead_band(sp_now));
        if (!toward)
            return 1'b0;
        if (scan_on)
        begin
            if (rev_now < COUNT_MAX)
                rev_now++;
            restart = set_velocity(-sp_now);
            led_now = cw;
        end
        else
        begin
            restart = set_velocity(0);
            latch_now = cw ? LIM_CW : LIM_CCW;
        end
        return restart;
    endfunction

    function automatic step_setup_t step_setup_for(logic [OP_W-1:0] op,
                                                   logic signed [VEL_W-1:0] v);
        step_setup_t s;
        bit restart;
        restart = 1'b0;
        case (op)
            OP_VELOCITY:  restart = set_velocity(longint'(v));
            OP_LIMIT_CW:  restart = hit_limit(1'b1);
            OP_LIMIT_CCW: restart = hit_limit(1'b0);
            default:      restart = 1'b0;
        endcase
        s.dir_cw          = dir_now;
        s.running         = run_now;
        s.step_period     = period_now;
        s.step_compare    = period_now[PERIOD_W-1:1];
        s.setpoint_out    = sp_now[VEL_W-1:0];
        s.latched_limit   = latch_now;
        s.reversals       = (rev_now > 65535) ? 16'hFFFF : rev_now[REV_W-1:0];
        s.scan_ready      = (rev_now >= 2);
        s.indicator       = led_now;
        s.counter_restart = restart;
        return s;
    endfunction

    task automatic send_cmd(logic [OP_W-1:0] op, logic signed [VEL_W-1:0] v);
        if (!no_idle)
        begin
            while ($urandom_range(0, 99) < IDLE_PCT)
            begin
                cmd_bus.valid <= 1'b0;
                @(posedge clk);
            end
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.op           <= op;
        cmd_bus.velocity_cmd <= v;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        expected_setups.push_back(step_setup_for(op, v));
        items_sent++;
    endtask

    task automatic send_random_cmd();
        int pick;
        int hi;
        logic [OP_W-1:0] op;
        logic signed [VEL_W-1:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            op = OP_VELOCITY;
        else if (pick < 72)
            op = OP_LIMIT_CW;
        else if (pick < 94)
            op = OP_LIMIT_CCW;
        else
            op = OP_UNUSED;
        hi = (speed_lim > SPEED_W'(4194203)) ? 4194303 : int'(speed_lim) + 100;
        case ($urandom_range(0, 3))
            0:       v = VEL_W'($urandom_range(0, 80));
            1:       v = VEL_W'($urandom_range(0, hi));
            default: v = VEL_W'($urandom());
        endcase
        if ($urandom_range(0, 1))
            v = -v;
        send_cmd(op, v);
    endtask

    // both registers in back-to-back cycles, only while the block is idle
    task automatic load_config(logic [SPEED_W-1:0] spd, bit scan);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_SPEED;
        cfg_data  <= spd;
        @(posedge clk);
        cfg_index <= CFG_SCAN_MODE;
        cfg_data  <= CFG_DATA_W'(scan);
        @(posedge clk);
        cfg_we <= 1'b0;
        speed_lim = spd;
        scan_on = scan;
        settings_loaded++;
    endtask

    task automatic settle();
        cmd_bus.valid <= 1'b0;
        while (expected_setups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_idle_state();
        send_cmd(OP_UNUSED, -23'sd1);
        send_cmd(OP_LIMIT_CW, 23'sd0);
        send_cmd(OP_LIMIT_CCW, 23'sd0);
        // dead band edge on both sides of zero
        send_cmd(OP_VELOCITY, 23'sd65);
        send_cmd(OP_VELOCITY, -23'sd65);
        send_cmd(OP_VELOCITY, 23'sd66);
        settle();
    endtask

    task automatic test_velocity_extremes();
        send_cmd(OP_VELOCITY, 23'sh3FFFFF);
        send_cmd(OP_VELOCITY, 23'sh400000);
        send_cmd(OP_VELOCITY, 23'sd0);
        send_cmd(OP_VELOCITY, -23'sd66);
        settle();
        load_config('1, 1'b1);
        send_cmd(OP_VELOCITY, 23'sh3FFFFF);
        send_cmd(OP_VELOCITY, 23'sh400000);
        send_cmd(OP_VELOCITY, 23'sd3276800);
        settle();
    endtask

    task automatic test_scan_reversal();
        load_config(MAX_SPEED_RESET, 1'b1);
        send_cmd(OP_VELOCITY, 23'sd1000);
        send_cmd(OP_LIMIT_CCW, 23'sd0);
        send_cmd(OP_LIMIT_CW, 23'sd0);
        send_cmd(OP_LIMIT_CW, 23'sd0);
        send_cmd(OP_LIMIT_CCW, 23'sd0);
        settle();
    endtask

    task automatic test_hold_latch();
        load_config(SPEED_W'(3276800), 1'b0);
        send_cmd(OP_VELOCITY, 23'sd5000);
        send_cmd(OP_LIMIT_CW, 23'sd0);
        send_cmd(OP_VELOCITY, 23'sd200);
        send_cmd(OP_VELOCITY, -23'sd200);
        send_cmd(OP_LIMIT_CCW, 23'sd0);
        send_cmd(OP_VELOCITY, -23'sd7);
        send_cmd(OP_VELOCITY, -23'sd300);
        settle();
    endtask

    task automatic test_zero_clamp();
        load_config('0, 1'b1);
        send_cmd(OP_VELOCITY, 23'sh3FFFFF);
        send_cmd(OP_VELOCITY, -23'sd1);
        send_cmd(OP_LIMIT_CW, 23'sd0);
        settle();
    endtask

    task automatic test_backpressure();
        load_config(SPEED_W'(3276800), 1'b1);
        no_idle = 1'b1;
        hold_off_req = 1'b1;
        repeat (12) send_random_cmd();
        no_idle = 1'b0;
        settle();
    endtask

    task automatic test_random_traffic();
        logic [SPEED_W-1:0] spd;
        int count;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:       spd = MAX_SPEED_RESET;
                1:       spd = SPEED_W'(3276800);
                2:       spd = '1;
                3:       spd = SPEED_W'(150);
                4:       spd = '0;
                default: spd = SPEED_W'($urandom_range(66, 3276800));
            endcase
            load_config(spd, (ph % 2) == 0);
            // one long stretch with both sides always willing
            no_idle = (ph == 1);
            count = (ph == 4) ? 60 : 270;
            repeat (count) send_random_cmd();
            no_idle = 1'b0;
            settle();
        end
    endtask

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        res_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                res_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            res_bus.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic compare_field(string what, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        step_setup_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (expected_setups.size() == 0)
            begin
                $display("%0t: result item with nothing expected", $time);
                mismatches++;
            end
            else
            begin
                want = expected_setups.pop_front();
                compare_field("dir_cw", want.dir_cw, res_bus.dir_cw);
                compare_field("running", want.running, res_bus.running);
                compare_field("step_period", want.step_period, res_bus.step_period);
                compare_field("step_compare", want.step_compare, res_bus.step_compare);
                compare_field("setpoint_out", longint'(want.setpoint_out),
                              longint'(res_bus.setpoint_out));
                compare_field("latched_limit", want.latched_limit, res_bus.latched_limit);
                compare_field("reversals", want.reversals, res_bus.reversals);
                compare_field("scan_ready", want.scan_ready, res_bus.scan_ready);
                compare_field("indicator", want.indicator, res_bus.indicator);
                compare_field("counter_restart", want.counter_restart,
                              res_bus.counter_restart);
                if (want.counter_restart)
                    restarts_seen++;
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_setups.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_MAX_SPEED;
        cfg_data             = '0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.op           = OP_VELOCITY;
        cmd_bus.velocity_cmd = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_state();
        test_velocity_extremes();
        test_scan_reversal();
        test_hold_latch();
        test_zero_clamp();
        test_backpressure();
        test_random_traffic();
        settle();

        $display("covered %0d command and limit items over %0d register settings",
                 items_sent, settings_loaded);
        $display("checked %0d results, %0d counter restarts, reversal count reached %0d",
                 results_checked, restarts_seen, rev_now);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
